// ===== rtl/dvrt_pkg.sv =====
// Package for the distance-vector route table: constants, codes and types.
// No dependencies.
`default_nettype none
package dvrt_pkg;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic [7:0]  INFTY_RESET     = 8'd16;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd5;
  localparam logic [15:0] TOLARANCE_RESET = 16'd3;

  typedef enum logic [1:0] {
    KIND_ADV   = 2'd0,
    KIND_TOUCH = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_DUMP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_INSERT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_ENTRY   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_INFTY     = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_TOLARANCE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_APPLY,
    FSM_DUMP,
    FSM_SINGLE
  } fsm_t;

  // One route entry as held in a cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [5:0]  prefix;
    logic [7:0]  distance;
    logic [31:0] hop;
    logic        direct;
    logic [31:0] refresh;
  } entry_t;

  // Command from the controller to every cell.
  typedef struct packed {
    logic        shift;
    logic        tick;
    logic [31:0] round;
    logic [7:0]  infty;
    logic [15:0] timeout;
    logic [15:0] tolerance;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/dvrt_if.sv =====
// Valid/ready channel interface used for every port of the route table.
// Payload type is a parameter; no package dependency.
`default_nettype none
interface dvrt_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dvrt_cell.sv =====
// One slot of the route table ring. Each cycle it passes its entry to the next
// cell while a pass is in progress, and applies aging on a tick. Uses dvrt_pkg.
`default_nettype none
module dvrt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dvrt_pkg::cell_cmd_t cmd,
  input  wire dvrt_pkg::entry_t  ent_in,
  output dvrt_pkg::entry_t       ent_out
);
  import dvrt_pkg::*;
  entry_t ent_r, ent_nxt;
  logic [32:0] to_sum, tol_sum;

  always_comb begin
    ent_nxt = ent_r;
    to_sum  = {1'b0, ent_in.refresh} + {17'd0, cmd.timeout};
    tol_sum = {1'b0, ent_in.refresh} + {17'd0, cmd.tolerance};
    if (cmd.shift) begin
      ent_nxt = ent_in;
      if (cmd.tick && ent_in.valid) begin
        if (to_sum < {1'b0, cmd.round}) ent_nxt.valid = 1'b0;
        else if (tol_sum < {1'b0, cmd.round}) ent_nxt.distance = cmd.infty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.ip       <= ent_nxt.ip;
    ent_r.prefix   <= ent_nxt.prefix;
    ent_r.distance <= ent_nxt.distance;
    ent_r.hop      <= ent_nxt.hop;
    ent_r.direct   <= ent_nxt.direct;
    ent_r.refresh  <= ent_nxt.refresh;
  end

  assign ent_out = ent_r;
endmodule
`default_nettype wire

// ===== rtl/dvrt_ctrl.sv =====
// Controller: rotates the cell ring, locates matches and free slots, applies
// updates at the ring head and emits results. Uses dvrt_pkg.
`default_nettype none
module dvrt_ctrl #(
  parameter int TABLE_DEPTH = dvrt_pkg::DEFAULT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_kind,
  input  wire logic [31:0]        in_net_ip,
  input  wire logic [5:0]         in_prefix_len,
  input  wire logic [7:0]         in_given_distance,
  input  wire logic [31:0]        in_via_hop,
  input  wire logic [7:0]         in_link_cost,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [15:0]        cfg_wdata,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [31:0]             out_ip,
  output logic [5:0]              out_prefix,
  output logic [7:0]              out_distance,
  output logic [31:0]             out_next_hop,
  output logic                    out_direct,
  output logic                    out_last,
  output dvrt_pkg::cell_cmd_t     cmd,
  input  wire dvrt_pkg::entry_t   head,
  output dvrt_pkg::entry_t        head_mod
);
  import dvrt_pkg::*;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  fsm_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  kind_r;
  logic [31:0] ip_r, hop_r;
  logic [5:0]  pfx_r;
  logic [7:0]  given_r, nd_r;
  logic [7:0]  infty_r;
  logic [15:0] timeout_r, tol_r;
  logic [31:0] round_r;
  logic        found_r, free_r, fnd_nxt, fre_nxt;
  logic [IW-1:0] fidx_r, freeidx_r, fidx_nxt, freeidx_nxt;
  logic        ov_r;
  logic [2:0]  ost_r;
  logic [31:0] oip_r, ohop_r;
  logic [5:0]  opfx_r;
  logic [7:0]  odist_r;
  logic        odir_r, olast_r;
  logic [8:0]  sum;
  logic [7:0]  nd_c;
  logic        hit, cur, shift, out_free;
  logic [IW-1:0] pos;
  logic [2:0]  single_st;
  logic        pend_r;
  entry_t      pend_e_r;
  logic        dump_step, dump_end, dump_take, dump_emit, single_emit;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == FSM_IDLE);
  assign sum  = {1'b0, in_given_distance} + {1'b0, in_link_cost};
  assign nd_c = (sum > {1'b0, infty_r}) ? infty_r : sum[7:0];
  assign pos  = cnt_r[IW-1:0];
  assign hit  = head.valid && head.ip == ip_r && head.prefix == pfx_r;
  assign cur  = found_r ? (pos == fidx_r) : (pos == freeidx_r);

  assign dump_step   = (st_r == FSM_DUMP) && out_free;
  assign dump_end    = (cnt_r == CW'(TABLE_DEPTH));
  assign dump_take   = dump_step && !dump_end && head.valid;
  assign dump_emit   = dump_step && (dump_end || (head.valid && pend_r));
  assign single_emit = (st_r == FSM_SINGLE) && out_free;

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    fnd_nxt = found_r;
    fre_nxt = free_r;
    fidx_nxt = fidx_r;
    freeidx_nxt = freeidx_r;
    case (st_r)
      FSM_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          fnd_nxt = 1'b0;
          fre_nxt = 1'b0;
          case (kind_t'(in_kind))
            KIND_TICK: st_nxt = FSM_APPLY;
            KIND_DUMP: st_nxt = FSM_DUMP;
            default:   st_nxt = FSM_SEARCH;
          endcase
        end
      end
      FSM_SEARCH: begin
        if (hit && !found_r) begin
          fnd_nxt = 1'b1;
          fidx_nxt = pos;
        end
        if (!head.valid && !free_r) begin
          fre_nxt = 1'b1;
          freeidx_nxt = pos;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(TABLE_DEPTH - 1)) begin
          cnt_nxt = '0;
          st_nxt = FSM_APPLY;
        end
      end
      FSM_APPLY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(TABLE_DEPTH - 1)) st_nxt = FSM_SINGLE;
      end
      FSM_DUMP: begin
        if (out_free) begin
          if (dump_end) st_nxt = FSM_IDLE;
          else cnt_nxt = cnt_r + 1'b1;
        end
      end
      FSM_SINGLE: begin
        if (out_free) st_nxt = FSM_IDLE;
      end
      default: st_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    shift = 1'b0;
    head_mod = head;
    single_st = ST_DONE;
    case (st_r)
      FSM_SEARCH: shift = 1'b1;
      FSM_APPLY: begin
        shift = 1'b1;
        if (kind_r == KIND_ADV) begin
          if (found_r && cur) begin
            if (!head.direct && head.hop == hop_r) begin
              head_mod.distance = nd_r;
              if (nd_r < infty_r) head_mod.refresh = round_r;
            end else if (nd_r < head.distance) begin
              head_mod.distance = nd_r;
              head_mod.hop = hop_r;
              head_mod.direct = 1'b0;
              head_mod.refresh = round_r;
            end
          end else if (!found_r && free_r && cur && given_r < infty_r) begin
            head_mod = '{1'b1, ip_r, pfx_r, nd_r, hop_r, 1'b0, round_r};
          end
        end else if (kind_r == KIND_TOUCH) begin
          if (found_r && cur) begin
            head_mod.refresh = round_r;
            head_mod.distance = given_r;
            head_mod.direct = 1'b1;
            head_mod.hop = '0;
          end else if (!found_r && free_r && cur) begin
            head_mod = '{1'b1, ip_r, pfx_r, given_r, 32'd0, 1'b1, round_r};
          end
        end
      end
      FSM_DUMP: shift = out_free && !dump_end;
      default: shift = 1'b0;
    endcase
    if (kind_r == KIND_ADV && !found_r) begin
      if (given_r >= infty_r) single_st = ST_DONE;
      else single_st = free_r ? ST_INSERT : ST_FULL;
    end else if (kind_r == KIND_TOUCH && !found_r) begin
      single_st = free_r ? ST_INSERT : ST_FULL;
    end
    cmd.shift = shift;
    cmd.tick = (st_r == FSM_APPLY) && (kind_r == KIND_TICK);
    cmd.round = round_r;
    cmd.infty = infty_r;
    cmd.timeout = timeout_r;
    cmd.tolerance = tol_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FSM_IDLE;
      cnt_r <= '0;
      found_r <= 1'b0;
      free_r <= 1'b0;
      infty_r <= INFTY_RESET;
      timeout_r <= TIMEOUT_RESET;
      tol_r <= TOLARANCE_RESET;
      round_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      found_r <= fnd_nxt;
      free_r <= fre_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_INFTY:     infty_r <= cfg_wdata[7:0];
          REG_TIMEOUT:   timeout_r <= cfg_wdata;
          REG_TOLARANCE: tol_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (single_emit || dump_emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (single_emit && kind_r == KIND_TICK) round_r <= round_r + 1'b1;
      if (st_r == FSM_IDLE) pend_r <= 1'b0;
      else if (dump_take) pend_r <= 1'b1;
    end
  end

  // A dump holds back the latest valid entry until the next valid slot or
  // the end of the pass shows whether it is the final one.
  always_ff @(posedge clk) begin
    fidx_r <= fidx_nxt;
    freeidx_r <= freeidx_nxt;
    if (st_r == FSM_IDLE && in_valid) begin
      kind_r <= in_kind;
      ip_r <= in_net_ip;
      pfx_r <= in_prefix_len;
      given_r <= in_given_distance;
      hop_r <= in_via_hop;
      nd_r <= nd_c;
    end
    if (dump_take) pend_e_r <= head;
    if (single_emit) begin
      ost_r <= single_st;
      {oip_r, opfx_r, odist_r, ohop_r, odir_r} <= '0;
      olast_r <= 1'b1;
    end else if (dump_emit) begin
      if (!pend_r) begin
        ost_r <= ST_EMPTY;
        {oip_r, opfx_r, odist_r, ohop_r, odir_r} <= '0;
        olast_r <= 1'b1;
      end else begin
        ost_r <= ST_ENTRY;
        oip_r <= pend_e_r.ip;
        opfx_r <= pend_e_r.prefix;
        odist_r <= pend_e_r.distance;
        ohop_r <= pend_e_r.direct ? 32'd0 : pend_e_r.hop;
        odir_r <= pend_e_r.direct;
        olast_r <= dump_end;
      end
    end
  end

  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_ip       = oip_r;
  assign out_prefix   = opfx_r;
  assign out_distance = odist_r;
  assign out_next_hop = ohop_r;
  assign out_direct   = odir_r;
  assign out_last     = olast_r;
endmodule
`default_nettype wire

// ===== rtl/distance_vector_route_table.sv =====
// Top level of the distance-vector route table: ring of slot cells plus
// controller. Uses dvrt_pkg, dvrt_if, dvrt_cell and dvrt_ctrl.
// An advertisement or touch, once accepted, makes one ring pass to search and
// one to apply, then issues its result; a tick makes one pass to apply, then
// issues its result, and a dump makes one pass that emits entries; each may be
// held by output stalls. The slot ring rotates one cell per cycle during a pass,
// except while a dump waits on a full output register. The table accepts no new
// transaction until the current one has placed its final result in the output register.
`default_nettype none
module distance_vector_route_table #(
  parameter int TABLE_DEPTH = dvrt_pkg::DEFAULT_DEPTH
) (
  input wire logic clk,
  input wire logic rst_n,
  dvrt_if.sink     in_ch,
  dvrt_if.source   out_ch,
  dvrt_if.sink     cfg_ch
);
  import dvrt_pkg::*;
  cell_cmd_t cmd;
  entry_t    ring [TABLE_DEPTH];
  entry_t    cell_in [TABLE_DEPTH];
  entry_t    head_mod;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_in[g] = head_mod;
    end else begin : g_link
      assign cell_in[g] = ring[g-1];
    end
    dvrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .ent_in (cell_in[g]),
      .ent_out(ring[g])
    );
  end

  assign cfg_ch.ready = 1'b1;

  dvrt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_kind          (in_ch.data.kind),
    .in_net_ip        (in_ch.data.net_ip),
    .in_prefix_len    (in_ch.data.prefix_len),
    .in_given_distance(in_ch.data.given_distance),
    .in_via_hop       (in_ch.data.via_hop),
    .in_link_cost     (in_ch.data.link_cost),
    .cfg_we           (cfg_ch.valid),
    .cfg_idx          (cfg_ch.data.index),
    .cfg_wdata        (cfg_ch.data.value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.data.status),
    .out_ip           (out_ch.data.out_ip),
    .out_prefix       (out_ch.data.out_prefix),
    .out_distance     (out_ch.data.out_distance),
    .out_next_hop     (out_ch.data.out_next_hop),
    .out_direct       (out_ch.data.out_direct),
    .out_last         (out_ch.data.last),
    .cmd              (cmd),
    .head             (ring[TABLE_DEPTH-1]),
    .head_mod         (head_mod)
  );
endmodule
`default_nettype wire

// ===== test/dvrt_tb_pkg.sv =====
// Transaction types for the route table testbench: request, response and
// register write payloads carried by the dvrt_if channels. Depends on dvrt_pkg.
package dvrt_tb_pkg;
  import dvrt_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] net_ip;
    logic [5:0]  prefix_len;
    logic [7:0]  given_distance;
    logic [31:0] via_hop;
    logic [7:0]  link_cost;
  } route_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_ip;
    logic [5:0]  out_prefix;
    logic [7:0]  out_distance;
    logic [31:0] out_next_hop;
    logic        out_direct;
    logic        last;
  } route_rsp_t;

  typedef struct packed {
    reg_idx_t    index;
    logic [15:0] value;
  } cfg_wr_t;
endpackage

// ===== test/route_table_checker.sv =====
// Checker for the route table: watches the request, response and register
// channels, keeps its own copy of the table and compares every response.
// Depends on dvrt_pkg and dvrt_tb_pkg.
module route_table_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  dvrt_tb_pkg::route_req_t in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  dvrt_tb_pkg::route_rsp_t out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  dvrt_tb_pkg::cfg_wr_t   cfg_data,
  output int                     pending,
  output int                     fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dvrt_pkg::*;
  import dvrt_tb_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;

  logic        rt_valid [DEPTH];
  logic [31:0] rt_ip [DEPTH];
  logic [5:0]  rt_prefix [DEPTH];
  logic [7:0]  rt_dist [DEPTH];
  logic [31:0] rt_hop [DEPTH];
  logic        rt_direct [DEPTH];
  logic [31:0] rt_refresh [DEPTH];
  logic [31:0] round_num;
  logic [7:0]  infty;
  logic [15:0] timeout_r;
  logic [15:0] tolerance_r;
  route_rsp_t  route_rsp_q[$];

  assign pending = route_rsp_q.size();

  function automatic route_rsp_t status_only(status_t st);
    route_rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int lookup_route(logic [31:0] ip, logic [5:0] pfx);
    for (int i = 0; i < DEPTH; i++)
      if (rt_valid[i] && rt_ip[i] == ip && rt_prefix[i] == pfx) return i;
    return -1;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < DEPTH; i++)
      if (!rt_valid[i]) return i;
    return -1;
  endfunction

  task automatic add_route(int s, route_req_t r, logic [7:0] d, logic [31:0] hop, logic dir);
    rt_valid[s] = 1'b1;
    rt_ip[s] = r.net_ip;
    rt_prefix[s] = r.prefix_len;
    rt_dist[s] = d;
    rt_hop[s] = hop;
    rt_direct[s] = dir;
    rt_refresh[s] = round_num;
  endtask

  task automatic predict_route(route_req_t r);
    logic [8:0]  sum;
    logic [7:0]  nd;
    int          s;
    int          n;
    route_rsp_t  e;
    case (r.kind)
      KIND_ADV: begin
        sum = r.given_distance + r.link_cost;
        nd = (sum > infty) ? infty : sum[7:0];
        s = lookup_route(r.net_ip, r.prefix_len);
        if (s >= 0) begin
          if (!rt_direct[s] && rt_hop[s] == r.via_hop) begin
            rt_dist[s] = nd;
            if (nd < infty) rt_refresh[s] = round_num;
          end else if (nd < rt_dist[s]) begin
            rt_dist[s] = nd;
            rt_hop[s] = r.via_hop;
            rt_direct[s] = 1'b0;
            rt_refresh[s] = round_num;
          end
          route_rsp_q.push_back(status_only(ST_DONE));
        end else if (r.given_distance >= infty) begin
          route_rsp_q.push_back(status_only(ST_DONE));
        end else begin
          s = lowest_free();
          if (s < 0) begin
            route_rsp_q.push_back(status_only(ST_FULL));
          end else begin
            add_route(s, r, nd, r.via_hop, 1'b0);
            route_rsp_q.push_back(status_only(ST_INSERT));
          end
        end
      end
      KIND_TOUCH: begin
        s = lookup_route(r.net_ip, r.prefix_len);
        if (s >= 0) begin
          rt_refresh[s] = round_num;
          rt_dist[s] = r.given_distance;
          rt_direct[s] = 1'b1;
          rt_hop[s] = '0;
          route_rsp_q.push_back(status_only(ST_DONE));
        end else begin
          s = lowest_free();
          if (s < 0) begin
            route_rsp_q.push_back(status_only(ST_FULL));
          end else begin
            add_route(s, r, r.given_distance, '0, 1'b1);
            route_rsp_q.push_back(status_only(ST_INSERT));
          end
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (rt_valid[i]) begin
            if ({1'b0, rt_refresh[i]} + timeout_r < {1'b0, round_num})
              rt_valid[i] = 1'b0;
            else if ({1'b0, rt_refresh[i]} + tolerance_r < {1'b0, round_num})
              rt_dist[i] = infty;
          end
        end
        round_num = round_num + 1;
        route_rsp_q.push_back(status_only(ST_DONE));
      end
      default: begin
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (rt_valid[i]) begin
            e = '0;
            e.status = ST_ENTRY;
            e.out_ip = rt_ip[i];
            e.out_prefix = rt_prefix[i];
            e.out_distance = rt_dist[i];
            e.out_next_hop = rt_direct[i] ? '0 : rt_hop[i];
            e.out_direct = rt_direct[i];
            route_rsp_q.push_back(e);
            n++;
          end
        end
        if (n == 0) route_rsp_q.push_back(status_only(ST_EMPTY));
        else route_rsp_q[$].last = 1'b1;
      end
    endcase
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    route_rsp_t e;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) rt_valid[i] = 1'b0;
      round_num = '0;
      infty = INFTY_RESET;
      timeout_r = TIMEOUT_RESET;
      tolerance_r = TOLARANCE_RESET;
      route_rsp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_INFTY:     infty = cfg_data.value[7:0];
          REG_TIMEOUT:   timeout_r = cfg_data.value;
          REG_TOLARANCE: tolerance_r = cfg_data.value;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (route_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected response transaction: %p", out_data);
        end else begin
          e = route_rsp_q.pop_front();
          if (e.status !== out_data.status || e.out_ip !== out_data.out_ip ||
              e.out_prefix !== out_data.out_prefix ||
              e.out_distance !== out_data.out_distance ||
              e.out_next_hop !== out_data.out_next_hop ||
              e.out_direct !== out_data.out_direct || e.last !== out_data.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch at %0t: expected %p, got %p", $realtime, e, out_data);
          end
        end
      end
      if (in_valid && in_ready) predict_route(in_data);
    end
  end
endmodule

// ===== test/tb_distance_vector_route_table.sv =====
// Testbench top for the route table: clock, reset, request stimulus, register
// writes and response back-pressure. Depends on dvrt_pkg, dvrt_tb_pkg, dvrt_if,
// route_table_checker and distance_vector_route_table.
module tb_distance_vector_route_table;
  timeunit 1ns;
  timeprecision 1ps;
  import dvrt_pkg::*;
  import dvrt_tb_pkg::*;

  localparam int NUM_KEYS = 24;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   pending;
  int   fail_count;
  bit   hold_req = 1'b0;
  int   burst_left = 0;

  logic [31:0] key_ip [NUM_KEYS];
  logic [5:0]  key_pfx [NUM_KEYS];
  logic [31:0] hop_pool [4];

  dvrt_if #(.payload_t(route_req_t)) in_ch (clk);
  dvrt_if #(.payload_t(route_rsp_t)) out_ch (clk);
  dvrt_if #(.payload_t(cfg_wr_t))    cfg_ch (clk);

  distance_vector_route_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  route_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // Response side: mixed stall patterns, plus one long hold-off on request.
  initial begin
    int mode;
    int seg_left;
    int cnt;
    int hold_cnt;
    bit hold_done;
    mode = 0;
    seg_left = 0;
    cnt = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == 400) hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 2);
          seg_left = $urandom_range(10, 120);
        end
        seg_left--;
        cnt++;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (cnt % 4 == 0);
        endcase
      end
    end
  end

  task automatic send_route(route_req_t r);
    int gap;
    in_ch.data <= r;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(1, 20);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_ch.data <= '{index: idx, value: val};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic route_req_t make_req(kind_t k, logic [31:0] ip, logic [5:0] pfx,
                                          logic [7:0] g, logic [31:0] hop, logic [7:0] c);
    route_req_t r;
    r.kind = k;
    r.net_ip = ip;
    r.prefix_len = pfx;
    r.given_distance = g;
    r.via_hop = hop;
    r.link_cost = c;
    return r;
  endfunction

  function automatic route_req_t random_req();
    route_req_t r;
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, NUM_KEYS - 1);
    r.net_ip = key_ip[k];
    r.prefix_len = key_pfx[k];
    r.via_hop = hop_pool[$urandom_range(0, 3)];
    r.given_distance = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
    r.link_cost = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    if (sel < 45) r.kind = KIND_ADV;
    else if (sel < 62) r.kind = KIND_TOUCH;
    else if (sel < 80) r.kind = KIND_TICK;
    else r.kind = KIND_DUMP;
    if ($urandom_range(0, 9) == 0) begin
      r.net_ip = $urandom;
      r.prefix_len = 6'($urandom);
      r.via_hop = $urandom;
      r.given_distance = 8'($urandom);
      r.link_cost = 8'($urandom);
    end
    return r;
  endfunction

  initial begin
    logic [15:0] cfg_set [6][3];
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    cfg_set = '{'{16'd16, 16'd5, 16'd3}, '{16'd255, 16'd0, 16'd0},
                '{16'd255, 16'd65535, 16'd65535}, '{16'd1, 16'd4, 16'd2},
                '{16'd0, 16'd2, 16'd1}, '{16'd40, 16'd8, 16'd3}};
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_ip[i] = $urandom;
      key_pfx[i] = 6'($urandom_range(0, 32));
    end
    key_ip[0] = '0;
    key_pfx[0] = 6'd0;
    key_ip[1] = '1;
    key_pfx[1] = 6'd63;
    key_ip[2] = key_ip[3];
    key_pfx[2] = key_pfx[3] ^ 6'd1;
    hop_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_route(make_req(KIND_DUMP, '0, '0, '0, '0, '0));
    send_route(make_req(KIND_TOUCH, '0, 6'd0, 8'd0, '0, '0));
    send_route(make_req(KIND_TOUCH, '1, 6'd63, 8'd255, '1, '1));
    send_route(make_req(KIND_ADV, 32'h0A00_0000, 6'd8, 8'd16, 32'h1, 8'd0));
    send_route(make_req(KIND_ADV, 32'h0A00_0000, 6'd8, 8'd10, 32'h1, 8'd200));
    send_route(make_req(KIND_ADV, 32'h0A00_0000, 6'd8, 8'd3, 32'h1, 8'd0));
    send_route(make_req(KIND_ADV, 32'h0A00_0000, 6'd8, 8'd1, 32'h2, 8'd1));
    send_route(make_req(KIND_ADV, 32'h0A00_0000, 6'd8, 8'd9, 32'h3, 8'd1));
    send_route(make_req(KIND_ADV, '1, 6'd63, 8'd0, 32'hFFFF_FFFF, 8'd1));
    send_route(make_req(KIND_ADV, 32'h0A00_0000, 6'd8, 8'd255, 32'h2, 8'd255));
    send_route(make_req(KIND_DUMP, '0, '0, '0, '0, '0));
    for (int i = 0; i < 6; i++) begin
      send_route(make_req(KIND_TICK, '0, '0, '0, '0, '0));
      if (i % 2 == 1) send_route(make_req(KIND_DUMP, '0, '0, '0, '0, '0));
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_reg(REG_INFTY, cfg_set[p][0]);
      write_reg(REG_TIMEOUT, cfg_set[p][1]);
      write_reg(REG_TOLARANCE, cfg_set[p][2]);
      cfg_ch.valid <= 1'b0;
      for (int n = 0; n < 68; n++) begin
        if (p == 2 && n == 30) hold_req = 1'b1;
        send_route(random_req());
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
